@@ rtl/ffba_pkg.sv @@
// Shared types and codes for the first-fit block allocator.
package ffba_pkg;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_NOFIT = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic       REG_POOL_BASE = 1'b0;
  localparam logic       REG_POOL_SIZE = 1'b1;

  typedef struct packed {
    logic shift;
    logic load;
  } ring_ctl_t;

endpackage

@@ rtl/ffba_cell.sv @@
// One descriptor cell of the rotating descriptor ring.
module ffba_cell import ffba_pkg::*; #(
  parameter int AW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ring_ctl_t     ctl,
  input  logic          nb_valid,
  input  logic [AW-1:0] nb_start,
  input  logic [AW-1:0] nb_len,
  input  logic          load_valid,
  input  logic [AW-1:0] load_start,
  input  logic [AW-1:0] load_len,
  output logic          valid,
  output logic [AW-1:0] start,
  output logic [AW-1:0] len
);

  logic          valid_r;
  logic [AW-1:0] start_r;
  logic [AW-1:0] len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.load) begin
      valid_r <= load_valid;
    end else if (ctl.shift) begin
      valid_r <= nb_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      start_r <= load_start;
      len_r   <= load_len;
    end else if (ctl.shift) begin
      start_r <= nb_start;
      len_r   <= nb_len;
    end
  end

  assign valid = valid_r;
  assign start = start_r;
  assign len   = len_r;

endmodule

@@ rtl/ffba_ctrl.sv @@
// Request sequencer at the head of the descriptor ring.
module ffba_ctrl import ffba_pkg::*; #(
  parameter int N  = 64,
  parameter int AW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rebuild,
  input  logic [AW-1:0] rebuild_size,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_op,
  input  logic [AW-1:0] in_size,
  input  logic [AW-1:0] in_addr,
  input  logic          c0_v,
  input  logic [AW-1:0] c0_s,
  input  logic [AW-1:0] c0_l,
  input  logic          c1_v,
  input  logic [AW-1:0] c1_s,
  input  logic [AW-1:0] c1_l,
  output ring_ctl_t     ring_ctl,
  output logic          y_v,
  output logic [AW-1:0] y_s,
  output logic [AW-1:0] y_l,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [31:0]   out_addr,
  output logic [1:0]    out_status,
  output logic [31:0]   out_total
);

  localparam int TW = $clog2(N);
  localparam int CW = $clog2(N + 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_t;
  typedef enum logic [2:0] {M_PASS, M_AHEAD, M_BEHIND, M_NEW, M_MOD} mode_t;

  state_t        state_r;
  mode_t         mode_r, mode_nxt;
  logic          done_r, done_nxt;
  logic [TW-1:0] t_r;
  logic          op_r;
  logic [AW-1:0] size_r, addr_r;
  logic          q_v_r, q_v_nxt;
  logic [AW-1:0] q_s_r, q_s_nxt, q_l_r, q_l_nxt;
  logic [AW-1:0] total_r, total_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] res_r, res_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          out_valid_r;
  logic [31:0]   out_addr_r, out_total_r;
  logic [1:0]    out_status_r;

  logic          last, v1m, full;
  logic [AW-1:0] end_a, newlen;
  logic          alloc_hit, free_nop, free_prv, jp, jn_nop, jn_prv;
  logic          quick;

  assign last   = (t_r == TW'(N - 1));
  assign v1m    = c1_v && !last;
  assign full   = (count_r == CW'(N));
  assign end_a  = addr_r + size_r;
  assign newlen = c0_l - size_r;

  assign alloc_hit = (op_r == OP_ALLOC) && c0_v && (c0_l >= size_r);
  assign free_nop  = (op_r == OP_FREE) && (t_r == '0) && (!c0_v || addr_r < c0_s);
  assign free_prv  = (op_r == OP_FREE) && c0_v && (addr_r >= c0_s) &&
                     (!v1m || addr_r < c1_s);
  assign jp        = (c0_s + c0_l == addr_r);
  assign jn_nop    = c0_v && (end_a == c0_s);
  assign jn_prv    = v1m && (end_a == c1_s);

  assign quick = (in_op == OP_ALLOC) ? (in_size == '0 || in_size > total_r)
                                     : (in_size == '0);

  always_comb begin
    y_v        = c0_v;
    y_s        = c0_s;
    y_l        = c0_l;
    mode_nxt   = mode_r;
    done_nxt   = done_r;
    q_v_nxt    = q_v_r;
    q_s_nxt    = q_s_r;
    q_l_nxt    = q_l_r;
    total_nxt  = total_r;
    count_nxt  = count_r;
    res_nxt    = res_r;
    status_nxt = status_r;
    unique case (mode_r)
      M_PASS: begin
        if (!done_r) begin
          if (alloc_hit) begin
            done_nxt   = 1'b1;
            status_nxt = STATUS_DONE;
            res_nxt    = c0_s + newlen;
            total_nxt  = total_r - size_r;
            if (newlen == '0) begin
              y_v       = v1m;
              y_s       = c1_s;
              y_l       = c1_l;
              mode_nxt  = M_AHEAD;
              count_nxt = count_r - CW'(1);
            end else begin
              y_l = newlen;
            end
          end else if (free_nop) begin
            done_nxt = 1'b1;
            if (jn_nop) begin
              y_s       = addr_r;
              y_l       = c0_l + size_r;
              total_nxt = total_r + size_r;
            end else if (full) begin
              status_nxt = STATUS_FULL;
            end else begin
              y_v       = 1'b1;
              y_s       = addr_r;
              y_l       = size_r;
              q_v_nxt   = c0_v;
              q_s_nxt   = c0_s;
              q_l_nxt   = c0_l;
              mode_nxt  = M_BEHIND;
              count_nxt = count_r + CW'(1);
              total_nxt = total_r + size_r;
            end
          end else if (free_prv) begin
            done_nxt = 1'b1;
            if (jp && jn_prv) begin
              y_l       = c0_l + size_r + c1_l;
              mode_nxt  = M_AHEAD;
              count_nxt = count_r - CW'(1);
              total_nxt = total_r + size_r;
            end else if (jp) begin
              y_l       = c0_l + size_r;
              total_nxt = total_r + size_r;
            end else if (jn_prv) begin
              mode_nxt  = M_MOD;
              total_nxt = total_r + size_r;
            end else if (full) begin
              status_nxt = STATUS_FULL;
            end else begin
              mode_nxt  = M_NEW;
              count_nxt = count_r + CW'(1);
              total_nxt = total_r + size_r;
            end
          end
        end
      end
      M_AHEAD: begin
        y_v = v1m;
        y_s = c1_s;
        y_l = c1_l;
      end
      M_BEHIND: begin
        y_v     = q_v_r;
        y_s     = q_s_r;
        y_l     = q_l_r;
        q_v_nxt = c0_v;
        q_s_nxt = c0_s;
        q_l_nxt = c0_l;
      end
      M_NEW: begin
        y_v      = 1'b1;
        y_s      = addr_r;
        y_l      = size_r;
        q_v_nxt  = c0_v;
        q_s_nxt  = c0_s;
        q_l_nxt  = c0_l;
        mode_nxt = M_BEHIND;
      end
      M_MOD: begin
        y_s      = addr_r;
        y_l      = c0_l + size_r;
        mode_nxt = M_PASS;
      end
      default: begin
        mode_nxt = M_PASS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_PASS;
      done_r      <= 1'b0;
      t_r         <= '0;
      total_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= STATUS_DONE;
      res_r       <= '0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      if (rebuild) begin
        total_r <= rebuild_size;
        count_r <= (rebuild_size != '0) ? CW'(1) : '0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_op;
            size_r   <= in_size;
            addr_r   <= in_addr;
            status_r <= (in_op == OP_ALLOC) ? STATUS_NOFIT : STATUS_DONE;
            res_r    <= '0;
            done_r   <= 1'b0;
            mode_r   <= M_PASS;
            t_r      <= '0;
            state_r  <= quick ? S_FIN : S_RUN;
          end
        end
        S_RUN: begin
          mode_r   <= mode_nxt;
          done_r   <= done_nxt;
          q_v_r    <= q_v_nxt;
          q_s_r    <= q_s_nxt;
          q_l_r    <= q_l_nxt;
          total_r  <= total_nxt;
          count_r  <= count_nxt;
          res_r    <= res_nxt;
          status_r <= status_nxt;
          t_r      <= t_r + TW'(1);
          if (last) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_addr_r   <= 32'(res_r);
            out_status_r <= status_r;
            out_total_r  <= 32'(total_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign ring_ctl.shift = (state_r == S_RUN);
  assign ring_ctl.load  = rebuild;
  assign out_valid      = out_valid_r;
  assign out_addr       = out_addr_r;
  assign out_status     = out_status_r;
  assign out_total      = out_total_r;

endmodule

@@ rtl/first_fit_block_allocator_core.sv @@
// First-fit block allocator: descriptor ring, sequencer and register port.
// Each request rotates the descriptor ring once: taken in S_IDLE, walked
// in S_RUN, result issued from S_FIN once the output port is free;
// trivial requests skip the walk. The next request is taken only after
// the result is issued. rst_n is synchronous active low: registers clear
// and the free list is empty; a register write rebuilds the list.
module first_fit_block_allocator_core import ffba_pkg::*; #(
  parameter int TABLE_ENTRIES = 64,
  parameter int ADDR_WIDTH    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // request_size[31:0], block_address[63:32]
  input  logic        in_tuser,   // operation[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // result_address[31:0], free_total[63:32]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int N  = TABLE_ENTRIES;
  localparam int AW = ADDR_WIDTH;

  logic [31:0]   base_r, base_nxt, size_r, size_nxt;
  logic          cfg_wr;
  ring_ctl_t     ring_ctl;
  logic          cv [N+1];
  logic [AW-1:0] cs [N+1];
  logic [AW-1:0] cl [N+1];
  logic [31:0]   res_addr, res_total;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign base_nxt   = (cfg_wr && cfg_paddr[2] == REG_POOL_BASE) ? cfg_pwdata : base_r;
  assign size_nxt   = (cfg_wr && cfg_paddr[2] == REG_POOL_SIZE) ? cfg_pwdata : size_r;
  assign cfg_prdata = (cfg_paddr[2] == REG_POOL_SIZE) ? size_r : base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      size_r <= '0;
    end else begin
      base_r <= base_nxt;
      size_r <= size_nxt;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cell
    ffba_cell #(.AW(AW)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ring_ctl),
      .nb_valid   (cv[i+1]),
      .nb_start   (cs[i+1]),
      .nb_len     (cl[i+1]),
      .load_valid ((i == 0) && (AW'(size_nxt) != '0)),
      .load_start (AW'(base_nxt)),
      .load_len   (AW'(size_nxt)),
      .valid      (cv[i]),
      .start      (cs[i]),
      .len        (cl[i])
    );
  end

  ffba_ctrl #(.N(N), .AW(AW)) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .rebuild      (cfg_wr),
    .rebuild_size (AW'(size_nxt)),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_op        (in_tuser),
    .in_size      (AW'(in_tdata[31:0])),
    .in_addr      (AW'(in_tdata[63:32])),
    .c0_v         (cv[0]),
    .c0_s         (cs[0]),
    .c0_l         (cl[0]),
    .c1_v         (cv[1]),
    .c1_s         (cs[1]),
    .c1_l         (cl[1]),
    .ring_ctl     (ring_ctl),
    .y_v          (cv[N]),
    .y_s          (cs[N]),
    .y_l          (cl[N]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_addr     (res_addr),
    .out_status   (out_tuser),
    .out_total    (res_total)
  );

  assign out_tdata = {res_total, res_addr};

endmodule
